// ===== rtl/pfs_pkg.sv =====
// pfs_pkg: shared types, byte codes and constants for the pixel frame serializer.
// No dependencies; used by every rtl file through scoped names.
`timescale 1ns / 1ps

package pfs_pkg;

    localparam int FRAME_PIXELS_DEF = 64;
    localparam int ROW_PIXELS_DEF   = 8;

    localparam int MAX_BYTES = 12;
    localparam int CNT_W     = 4;

    // APB register map
    localparam int  PADDR_W              = 2;
    localparam logic [PADDR_W-1:0] REG_FRAME_FORMAT = 2'd0;

    // frame_format codes
    localparam logic [1:0] FMT_OFF    = 2'd0;
    localparam logic [1:0] FMT_BINARY = 2'd1;
    localparam logic [1:0] FMT_TEXT   = 2'd2;

    typedef logic [7:0] byte_t;

    localparam byte_t HDR_0     = 8'hBB;
    localparam byte_t HDR_1     = 8'hAA;
    localparam byte_t HDR_2     = 8'h41;
    localparam byte_t CH_LBRACK = 8'h5B;
    localparam byte_t CH_RBRACK = 8'h5D;
    localparam byte_t CH_POINT  = 8'h2E;
    localparam byte_t CH_MINUS  = 8'h2D;
    localparam byte_t CH_SPACE  = 8'h20;
    localparam byte_t CH_ZERO   = 8'h30;
    localparam byte_t CH_CR     = 8'h0D;
    localparam byte_t CH_LF     = 8'h0A;

    // Reciprocal constants, exact for scaled values up to 81920
    localparam logic [20:0] RECIP_10     = 21'd1677722;  // 2^24 / 10
    localparam logic [17:0] RECIP_100    = 18'd167773;   // 2^24 / 100
    localparam logic [18:0] RECIP_1000   = 19'd268436;   // 2^28 / 1000
    localparam logic [7:0]  RECIP_10_SML = 8'd205;       // 2^11 / 10, inputs below 1029

    typedef logic [3:0] digit_t;

    typedef struct packed {
        digit_t d3;
        digit_t d2;
        digit_t d1;
        digit_t d0;
    } digits_t;

    typedef struct packed {
        logic        text;
        logic [15:0] raw;
        logic        first;
        logic        last;
        logic        row_open;
        logic        row_close;
        byte_t       csum;
    } item_t;

endpackage

// ===== rtl/pfs_track.sv =====
// pfs_track: frame position, row column and checksum tracking plus the input register.
// Depends on pfs_pkg.
`timescale 1ns / 1ps

module pfs_track #(
    parameter int FRAME_PIXELS = pfs_pkg::FRAME_PIXELS_DEF,
    parameter int ROW_PIXELS   = pfs_pkg::ROW_PIXELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr,
    input  logic [1:0]          frame_format,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         in_pixel,
    output logic                out_valid,
    input  logic                out_ready,
    output pfs_pkg::item_t      out_item
);

    localparam int POS_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int COL_W = (ROW_PIXELS > 1) ? $clog2(ROW_PIXELS) : 1;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [COL_W-1:0] col_reg, col_next;
    pfs_pkg::byte_t   sum_reg, sum_next;
    logic             a_valid_reg, a_valid_next;
    pfs_pkg::item_t   a_item_reg;
    pfs_pkg::item_t   item_new;

    logic accept;
    logic active;
    logic first;
    logic last;
    logic row_close;

    assign in_ready  = !a_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign active    = (frame_format == pfs_pkg::FMT_BINARY)
                    || (frame_format == pfs_pkg::FMT_TEXT);
    assign first     = (pos_reg == '0);
    assign last      = (pos_reg == POS_W'(FRAME_PIXELS - 1));
    assign row_close = (col_reg == COL_W'(ROW_PIXELS - 1)) || last;

    always_comb
    begin
        item_new.text      = (frame_format == pfs_pkg::FMT_TEXT);
        item_new.raw       = in_pixel;
        item_new.first     = first;
        item_new.last      = last;
        item_new.row_open  = (col_reg == '0);
        item_new.row_close = row_close;
        item_new.csum      = (first ? 8'd0 : sum_reg) + in_pixel[7:0] + in_pixel[15:8];
    end

    always_comb
    begin
        pos_next = pos_reg;
        col_next = col_reg;
        sum_next = sum_reg;
        if (cfg_wr)
        begin
            pos_next = '0;
            col_next = '0;
            sum_next = '0;
        end
        else if (accept)
        begin
            if (!active || last)
            begin
                pos_next = '0;
                col_next = '0;
                sum_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                col_next = row_close ? '0 : col_reg + 1'b1;
                sum_next = item_new.csum;
            end
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_ready)
        begin
            a_valid_next = accept && active;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            col_reg     <= '0;
            sum_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            col_reg     <= col_next;
            sum_reg     <= sum_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg <= item_new;
        end
    end

    assign out_valid = a_valid_reg;
    assign out_item  = a_item_reg;

endmodule

// ===== rtl/pfs_scale.sv =====
// pfs_scale: scales a pixel by 10/4 and splits the magnitude into four decimal digits.
// Two register stages (scale, reciprocal quotients); digits leave combinationally. Uses pfs_pkg.
`timescale 1ns / 1ps

module pfs_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfs_pkg::item_t      in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output pfs_pkg::item_t      out_item,
    output pfs_pkg::digits_t    out_digits
);

    logic           b_valid_reg, b_valid_next;
    pfs_pkg::item_t b_item_reg;
    logic [16:0]    b_s_reg;
    logic           c_valid_reg, c_valid_next;
    pfs_pkg::item_t c_item_reg;
    logic [16:0]    c_s_reg;
    logic [13:0]    c_q10_reg;
    logic [9:0]     c_q100_reg;
    logic [6:0]     c_q1000_reg;

    logic        b_ready;
    logic        c_ready;
    logic [16:0] mag;
    logic [19:0] mag5;
    logic [37:0] p10;
    logic [34:0] p100;
    logic [35:0] p1000;
    logic [14:0] p10000;
    logic [3:0]  q10000;
    logic [16:0] r0;
    logic [13:0] r1;
    logic [9:0]  r2;
    logic [6:0]  r3;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign in_ready = b_ready;

    // magnitude of the reading, then times 10/4 truncated
    assign mag  = in_item.raw[15] ? (17'h10000 - {1'b0, in_item.raw}) : {1'b0, in_item.raw};
    assign mag5 = {3'b000, mag} + {1'b0, mag, 2'b00};

    assign p10   = 38'(b_s_reg) * 38'(pfs_pkg::RECIP_10);
    assign p100  = 35'(b_s_reg) * 35'(pfs_pkg::RECIP_100);
    assign p1000 = 36'(b_s_reg) * 36'(pfs_pkg::RECIP_1000);

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (b_ready)
        begin
            b_valid_next = in_valid;
        end
        c_valid_next = c_valid_reg;
        if (c_ready)
        begin
            c_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && in_valid)
        begin
            b_item_reg <= in_item;
            b_s_reg    <= mag5[17:1];
        end
        if (c_ready && b_valid_reg)
        begin
            c_item_reg  <= b_item_reg;
            c_s_reg     <= b_s_reg;
            c_q10_reg   <= p10[37:24];
            c_q100_reg  <= p100[33:24];
            c_q1000_reg <= p1000[34:28];
        end
    end

    // remainders give the digits; the ten-thousands place is dropped
    assign p10000 = 15'(c_q1000_reg) * 15'(pfs_pkg::RECIP_10_SML);
    assign q10000 = p10000[14:11];
    assign r0     = c_s_reg - 17'({c_q10_reg, 3'b000} + {c_q10_reg, 1'b0});
    assign r1     = c_q10_reg - 14'({c_q100_reg, 3'b000} + {c_q100_reg, 1'b0});
    assign r2     = c_q100_reg - 10'({c_q1000_reg, 3'b000} + {c_q1000_reg, 1'b0});
    assign r3     = c_q1000_reg - 7'({q10000, 3'b000} + {q10000, 1'b0});

    assign out_digits.d0 = r0[3:0];
    assign out_digits.d1 = r1[3:0];
    assign out_digits.d2 = r2[3:0];
    assign out_digits.d3 = r3[3:0];
    assign out_valid     = c_valid_reg;
    assign out_item      = c_item_reg;

endmodule

// ===== rtl/pfs_serial.sv =====
// pfs_serial: builds one pixel's byte run; shifts it out one beat per cycle unless stalled.
// Holds the byte run register and the output register. Uses pfs_pkg.
`timescale 1ns / 1ps

module pfs_serial (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfs_pkg::item_t      in_item,
    input  pfs_pkg::digits_t    in_digits,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // out_byte
    output logic                m_axis_tlast,   // end_of_frame
    output logic [0:0]          m_axis_tuser    // [0] last_of_item
);

    localparam int BUILD_N = pfs_pkg::MAX_BYTES + 1;

    pfs_pkg::byte_t                    job_bytes_reg [pfs_pkg::MAX_BYTES];
    pfs_pkg::byte_t                    job_bytes_next [pfs_pkg::MAX_BYTES];
    logic [pfs_pkg::CNT_W-1:0]         job_cnt_reg, job_cnt_next;
    logic                              job_eof_reg, job_eof_next;
    logic                              out_valid_reg;
    pfs_pkg::byte_t                    out_byte_reg;
    logic                              out_item_end_reg;
    logic                              out_eof_reg;

    pfs_pkg::byte_t            run [BUILD_N];
    logic [pfs_pkg::CNT_W-1:0] run_n;
    logic [pfs_pkg::CNT_W-1:0] run_cnt;
    logic                      emit;
    logic                      load;

    assign emit     = (job_cnt_reg != '0) && (!out_valid_reg || m_axis_tready);
    assign in_ready = (job_cnt_reg == '0)
                   || ((job_cnt_reg == pfs_pkg::CNT_W'(1)) && emit);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        for (int i = 0; i < BUILD_N; i++)
        begin
            run[i] = pfs_pkg::CH_SPACE;
        end
        run_n = '0;
        if (in_item.text)
        begin
            if (in_item.row_open)
            begin
                run[run_n] = pfs_pkg::CH_LBRACK;
                run_n      = run_n + 1'b1;
            end
            run[run_n] = in_item.raw[15] ? pfs_pkg::CH_MINUS : pfs_pkg::CH_SPACE;
            run_n      = run_n + 1'b1;
            run[run_n] = pfs_pkg::CH_ZERO + 8'(in_digits.d3);
            run_n      = run_n + 1'b1;
            run[run_n] = pfs_pkg::CH_ZERO + 8'(in_digits.d2);
            run_n      = run_n + 1'b1;
            run[run_n] = pfs_pkg::CH_ZERO + 8'(in_digits.d1);
            run_n      = run_n + 1'b1;
            run[run_n] = pfs_pkg::CH_POINT;
            run_n      = run_n + 1'b1;
            run[run_n] = pfs_pkg::CH_ZERO + 8'(in_digits.d0);
            run_n      = run_n + 1'b1;
            run[run_n] = pfs_pkg::CH_SPACE;
            run_n      = run_n + 1'b1;
            if (in_item.row_close)
            begin
                run[run_n] = pfs_pkg::CH_RBRACK;
                run_n      = run_n + 1'b1;
                run[run_n] = pfs_pkg::CH_CR;
                run_n      = run_n + 1'b1;
                run[run_n] = pfs_pkg::CH_LF;
                run_n      = run_n + 1'b1;
            end
            if (in_item.last)
            begin
                run[run_n] = pfs_pkg::CH_CR;
                run_n      = run_n + 1'b1;
                if (run_n < pfs_pkg::CNT_W'(BUILD_N))
                begin
                    run[run_n] = pfs_pkg::CH_LF;
                    run_n      = run_n + 1'b1;
                end
            end
        end
        else
        begin
            if (in_item.first)
            begin
                run[0] = pfs_pkg::HDR_0;
                run[1] = pfs_pkg::HDR_1;
                run[2] = pfs_pkg::HDR_2;
                run_n  = pfs_pkg::CNT_W'(3);
            end
            run[run_n] = in_item.raw[7:0];
            run_n      = run_n + 1'b1;
            run[run_n] = in_item.raw[15:8];
            run_n      = run_n + 1'b1;
            if (in_item.last)
            begin
                run[run_n] = in_item.csum;
                run_n      = run_n + 1'b1;
            end
        end
    end

    // a run longer than twelve loses its final byte
    assign run_cnt = (run_n > pfs_pkg::CNT_W'(pfs_pkg::MAX_BYTES))
                   ? pfs_pkg::CNT_W'(pfs_pkg::MAX_BYTES) : run_n;

    always_comb
    begin
        job_bytes_next = job_bytes_reg;
        job_cnt_next   = job_cnt_reg;
        job_eof_next   = job_eof_reg;
        if (emit)
        begin
            for (int i = 0; i < pfs_pkg::MAX_BYTES - 1; i++)
            begin
                job_bytes_next[i] = job_bytes_reg[i+1];
            end
            job_cnt_next = job_cnt_reg - 1'b1;
        end
        if (load)
        begin
            for (int i = 0; i < pfs_pkg::MAX_BYTES; i++)
            begin
                job_bytes_next[i] = run[i];
            end
            job_cnt_next = run_cnt;
            job_eof_next = in_item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_cnt_reg <= job_cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_bytes_reg <= job_bytes_next;
        job_eof_reg   <= job_eof_next;
        if (emit)
        begin
            out_byte_reg     <= job_bytes_reg[0];
            out_item_end_reg <= (job_cnt_reg == pfs_pkg::CNT_W'(1));
            out_eof_reg      <= (job_cnt_reg == pfs_pkg::CNT_W'(1)) && job_eof_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_byte_reg;
    assign m_axis_tlast    = out_eof_reg;
    assign m_axis_tuser[0] = out_item_end_reg;

endmodule

// ===== rtl/pixel_frame_serializer.sv =====
// pixel_frame_serializer: top level; APB register, pixel tracking, scaling and byte output.
// Instantiates pfs_track, pfs_scale and pfs_serial; uses pfs_pkg.
`timescale 1ns / 1ps

// Accepts one signed 16-bit pixel per input beat and emits the frame as one byte per output
// beat: binary (header BB AA 41, low/high bytes, 8-bit payload checksum after the last pixel)
// or text (sign, three digits, point, digit, space; rows in brackets ending CR LF, frame ending
// with a further CR LF). The output register sends one byte per cycle while m_axis_tready is
// high, so a pixel gives 2 to 6 bytes in binary and 7 to 12 in text; the next pixel is taken
// while the current run drains. A pixel passes the input, scale, quotient and byte run
// registers before the output register. Format 0 or 3 consumes pixels with no output.
// Writing frame_format restarts the frame; write it only while idle.

module pixel_frame_serializer #(
    parameter int FRAME_PIXELS = pfs_pkg::FRAME_PIXELS_DEF,
    parameter int ROW_PIXELS   = pfs_pkg::ROW_PIXELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pfs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,   // pixel_value
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // out_byte
    output logic                         m_axis_tlast,   // end_of_frame
    output logic [0:0]                   m_axis_tuser    // [0] last_of_item
);

    logic [1:0]       frame_format_reg;
    logic             cfg_wr;
    logic             a_valid;
    logic             a_ready;
    pfs_pkg::item_t   a_item;
    logic             c_valid;
    logic             c_ready;
    pfs_pkg::item_t   c_item;
    pfs_pkg::digits_t c_digits;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == pfs_pkg::REG_FRAME_FORMAT);
    assign prdata = (paddr == pfs_pkg::REG_FRAME_FORMAT) ? {30'd0, frame_format_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_format_reg <= pfs_pkg::FMT_OFF;
        end
        else if (cfg_wr)
        begin
            frame_format_reg <= pwdata[1:0];
        end
    end

    pfs_track #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .ROW_PIXELS   (ROW_PIXELS)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_wr),
        .frame_format (frame_format_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_pixel     (s_axis_tdata),
        .out_valid    (a_valid),
        .out_ready    (a_ready),
        .out_item     (a_item)
    );

    pfs_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (a_valid),
        .in_ready   (a_ready),
        .in_item    (a_item),
        .out_valid  (c_valid),
        .out_ready  (c_ready),
        .out_item   (c_item),
        .out_digits (c_digits)
    );

    pfs_serial u_serial (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (c_valid),
        .in_ready      (c_ready),
        .in_item       (c_item),
        .in_digits     (c_digits),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
